// ===== hw/rtl/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared command type, field widths and operation codes of the byte ring
// buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int FUNC_W = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 12;

   // request selector codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SKIP      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COMMIT_WR = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_COMMIT_RD = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd6;

   // internal operation codes after classification
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
   localparam logic [OP_W-1:0] OP_ADV_RD = 3'd4;
   localparam logic [OP_W-1:0] OP_ADV_WR = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QIW    = 1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data;
      logic [CNT_W-1:0]  count;
   } cmd_type;

endpackage

// ===== hw/rtl/brb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// brb_cmd_queue
// Two-entry command queue that decouples the request front from the
// execution back.
// ----------------------------------------------------------------------------
module brb_cmd_queue
   import brb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    q_valid,
   output cmd_type q_cmd,
   output logic    full
);

   localparam int FW = $clog2(QDEPTH + 1);

   cmd_type          slot_ff [QDEPTH];
   logic [QIW-1:0]   wr_idx_ff;
   logic [QIW-1:0]   wr_idx_in;
   logic [QIW-1:0]   rd_idx_ff;
   logic [QIW-1:0]   rd_idx_in;
   logic [FW-1:0]    fill_ff;
   logic [FW-1:0]    fill_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (fill_ff == FW'(QDEPTH));
   assign q_valid = (fill_ff != '0);
   assign q_cmd   = slot_ff[rd_idx_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_idx_in = do_push ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = do_pop ? rd_idx_ff + 1'b1 : rd_idx_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_idx_ff] <= push_cmd;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QDEPTH))
      else $error("command queue fill exceeds its depth");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !(pop && q_valid)) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("command queue lost a push");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !q_valid |=> fill_ff <= FW'(1))
      else $error("command queue underflow");

endmodule

// ===== hw/rtl/brb_front.sv =====
// ----------------------------------------------------------------------------
// brb_front
// Request front: takes request beats, classifies the selector into an
// internal operation and clamps read and peek bursts.
// ----------------------------------------------------------------------------
module brb_front
   import brb_pkg::*;
#(
   parameter int MAX_BURST = 64
)
(
   input  logic              start,
   output logic              busy,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [CNT_W-1:0]  req_count,
   input  logic              full,
   output logic              push,
   output cmd_type           push_cmd
);

   localparam logic [CNT_W-1:0] BURST_CAP = CNT_W'(MAX_BURST);

   logic [CNT_W-1:0] burst_cnt;

   assign busy      = full;
   assign push      = start && !full;
   assign burst_cnt = (req_count > BURST_CAP) ? BURST_CAP : req_count;

   always_comb begin
      push_cmd.data  = req_data_byte;
      push_cmd.count = req_count;
      case (req_func)
         FUNC_WRITE:     push_cmd.op = OP_WRITE;
         FUNC_READ: begin
            push_cmd.op    = OP_READ;
            push_cmd.count = burst_cnt;
         end
         FUNC_PEEK: begin
            push_cmd.op    = OP_PEEK;
            push_cmd.count = burst_cnt;
         end
         FUNC_SKIP:      push_cmd.op = OP_ADV_RD;
         FUNC_COMMIT_RD: push_cmd.op = OP_ADV_RD;
         FUNC_COMMIT_WR: push_cmd.op = OP_ADV_WR;
         FUNC_CLEAR:     push_cmd.op = OP_CLEAR;
         default:        push_cmd.op = OP_NOP;
      endcase
   end

endmodule

// ===== hw/rtl/brb_back.sv =====
// ----------------------------------------------------------------------------
// brb_back
// Execution back: owns the pointers and the byte store, carries out one
// command at a time and drives the registered response beats.
// ----------------------------------------------------------------------------
module brb_back
   import brb_pkg::*;
#(
   parameter int DEPTH     = 4096,
   parameter int MAX_BURST = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last,
   output logic [CNT_W-1:0]  rsp_done_count,
   output logic [CNT_W-1:0]  rsp_used_bytes,
   output logic [CNT_W-1:0]  rsp_free_bytes,
   output logic [CNT_W-1:0]  rsp_contig_read,
   output logic [CNT_W-1:0]  rsp_contig_write
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = PW + 1;
   localparam int LW = (CW > CNT_W) ? CW : CNT_W;
   localparam int BW = $clog2(MAX_BURST + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_BURST = 2'd2;

   logic [1:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [PW-1:0]     rp_ff, rp_in;
   logic [PW-1:0]     wp_ff, wp_in;
   logic [PW-1:0]     burst_addr_ff, burst_addr_in;
   logic [BW-1:0]     burst_left_ff, burst_left_in;
   logic [CW-1:0]     burst_n_ff, burst_n_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_bv_ff, pend_bv_in;
   logic              pend_last_ff, pend_last_in;
   logic [CW-1:0]     pend_done_ff, pend_done_in;
   logic [BYTE_W-1:0] mem_q_ff;
   logic              mem_we;
   logic [BYTE_W-1:0] mem [DEPTH];

   logic              rsp_strobe_ff;
   logic [BYTE_W-1:0] rsp_read_byte_ff;
   logic              rsp_byte_valid_ff;
   logic              rsp_last_ff;
   logic [CNT_W-1:0]  rsp_done_count_ff;
   logic [CNT_W-1:0]  rsp_used_bytes_ff;
   logic [CNT_W-1:0]  rsp_free_bytes_ff;
   logic [CNT_W-1:0]  rsp_contig_read_ff;
   logic [CNT_W-1:0]  rsp_contig_write_ff;

   logic [CW-1:0]     rp_ext, wp_ext;
   logic              wp_ge;
   logic [CW-1:0]     used_c, free_c, crd_c, cwr_c;
   logic [LW-1:0]     cnt_l;
   logic [CW-1:0]     rd_n, wr_n;

   function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] n);
      logic [CW-1:0] sum;
      sum = {1'b0, p} + n;
      if (sum >= DEPTH_C) begin
         sum = sum - DEPTH_C;
      end
      return sum[PW-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] to_cnt(input logic [CW-1:0] v);
      logic [LW-1:0] t;
      t = LW'(v);
      return t[CNT_W-1:0];
   endfunction

   // buffer status from the current pointers
   always_comb begin
      rp_ext = {1'b0, rp_ff};
      wp_ext = {1'b0, wp_ff};
      wp_ge  = (wp_ff >= rp_ff);
      used_c = wp_ge ? wp_ext - rp_ext : DEPTH_C - rp_ext + wp_ext;
      free_c = DEPTH_C - CW'(1) - used_c;
      crd_c  = wp_ge ? wp_ext - rp_ext : DEPTH_C - rp_ext;
      cwr_c  = wp_ge ? DEPTH_C - wp_ext - CW'(rp_ff == '0) : rp_ext - wp_ext - CW'(1);
      cnt_l  = LW'(cmd_ff.count);
      rd_n   = (cnt_l < LW'(used_c)) ? CW'(cnt_l) : used_c;
      wr_n   = (cnt_l < LW'(free_c)) ? CW'(cnt_l) : free_c;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      burst_addr_in = burst_addr_ff;
      burst_left_in = burst_left_ff;
      burst_n_in    = burst_n_ff;
      pend_valid_in = 1'b0;
      pend_bv_in    = 1'b0;
      pend_last_in  = 1'b1;
      pend_done_in  = '0;
      pop           = 1'b0;
      mem_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            pend_valid_in = 1'b1;
            case (cmd_ff.op)
               OP_WRITE: begin
                  if (free_c != '0) begin
                     mem_we       = 1'b1;
                     wp_in        = adv(wp_ff, CW'(1));
                     pend_done_in = CW'(1);
                  end
               end
               OP_READ, OP_PEEK: begin
                  if (rd_n != '0) begin
                     // status of every byte beat shows the pointers after the burst
                     pend_valid_in = 1'b0;
                     burst_addr_in = rp_ff;
                     burst_left_in = BW'(rd_n);
                     burst_n_in    = rd_n;
                     state_in      = S_BURST;
                     if (cmd_ff.op == OP_READ) begin
                        rp_in = adv(rp_ff, rd_n);
                     end
                  end
               end
               OP_ADV_RD: begin
                  rp_in        = adv(rp_ff, rd_n);
                  pend_done_in = rd_n;
               end
               OP_ADV_WR: begin
                  wp_in        = adv(wp_ff, wr_n);
                  pend_done_in = wr_n;
               end
               OP_CLEAR: begin
                  rp_in = '0;
                  wp_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_BURST: begin
            pend_valid_in = 1'b1;
            pend_bv_in    = 1'b1;
            pend_last_in  = (burst_left_ff == BW'(1));
            pend_done_in  = burst_n_ff;
            burst_addr_in = (burst_addr_ff == LAST_SLOT) ? '0 : burst_addr_ff + 1'b1;
            burst_left_in = burst_left_ff - 1'b1;
            if (burst_left_ff == BW'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rp_ff         <= '0;
         wp_ff         <= '0;
         burst_left_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         burst_left_ff <= burst_left_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff              <= cmd_in;
      burst_addr_ff       <= burst_addr_in;
      burst_n_ff          <= burst_n_in;
      pend_bv_ff          <= pend_bv_in;
      pend_last_ff        <= pend_last_in;
      pend_done_ff        <= pend_done_in;
      rsp_read_byte_ff    <= pend_bv_ff ? mem_q_ff : '0;
      rsp_byte_valid_ff   <= pend_bv_ff;
      rsp_last_ff         <= pend_last_ff;
      rsp_done_count_ff   <= to_cnt(pend_done_ff);
      rsp_used_bytes_ff   <= to_cnt(used_c);
      rsp_free_bytes_ff   <= to_cnt(free_c);
      rsp_contig_read_ff  <= to_cnt(crd_c);
      rsp_contig_write_ff <= to_cnt(cwr_c);
   end

   // byte store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= cmd_ff.data;
      end
      mem_q_ff <= mem[burst_addr_ff];
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_byte    = rsp_read_byte_ff;
   assign rsp_byte_valid   = rsp_byte_valid_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_done_count   = rsp_done_count_ff;
   assign rsp_used_bytes   = rsp_used_bytes_ff;
   assign rsp_free_bytes   = rsp_free_bytes_ff;
   assign rsp_contig_read  = rsp_contig_read_ff;
   assign rsp_contig_write = rsp_contig_write_ff;

   a_status_beat_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_byte_valid) |-> rsp_last)
      else $error("status-only beat without last");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (rp_ext < DEPTH_C) && (wp_ext < DEPTH_C))
      else $error("pointer beyond buffer depth");

   a_burst_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BURST) |-> (burst_left_ff != '0))
      else $error("burst state with no bytes left");

   a_pop_exec: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == S_EXEC))
      else $error("popped command not executed");

endmodule

// ===== hw/rtl/byte_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte buffer with one slot kept empty: request front, two-entry
// command queue and execution back with the byte store.
// ----------------------------------------------------------------------------
// status beat path: command queue, command register, pending beat register,
// response register; a read or peek adds the burst state and the byte store
// read register before its byte beats, which follow one per cycle from the
// byte store; the back carries out one command at a time
// busy is high while the command queue holds two commands
// reset clears both pointers, the queue and the strobe; stored bytes are kept
// response beats cannot be stalled by the receiver
module byte_ring_buffer
   import brb_pkg::*;
#(
   parameter int DEPTH     = 4096,
   parameter int MAX_BURST = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [CNT_W-1:0]  req_count,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last,
   output logic [CNT_W-1:0]  rsp_done_count,
   output logic [CNT_W-1:0]  rsp_used_bytes,
   output logic [CNT_W-1:0]  rsp_free_bytes,
   output logic [CNT_W-1:0]  rsp_contig_read,
   output logic [CNT_W-1:0]  rsp_contig_write
);

   logic    full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    q_valid;
   cmd_type q_cmd;

   brb_front #(
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .req_count     (req_count),
      .full          (full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   brb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .full     (full)
   );

   brb_back #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_done_count   (rsp_done_count),
      .rsp_used_bytes   (rsp_used_bytes),
      .rsp_free_bytes   (rsp_free_bytes),
      .rsp_contig_read  (rsp_contig_read),
      .rsp_contig_write (rsp_contig_write)
   );

endmodule
